// ===== src/perf_sample_record_parser_assert.svh =====
// Assertion macros shared by the perf sample record parser RTL.
`ifndef PERF_SAMPLE_RECORD_PARSER_ASSERT_SVH
`define PERF_SAMPLE_RECORD_PARSER_ASSERT_SVH

`ifndef SYNTHESIS

`define PSR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

`define PSR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`else

`define PSR_ASSERT_IMPLY(label, clk, rst, ante, cons)

`define PSR_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== src/psr_pkg.sv =====
// Package with types, codes and constants of the perf sample record parser.
`timescale 1ns / 1ps
package psr_pkg;

   localparam int MAX_GROUP_VALUES_DEF = 64;
   localparam int CSR_INDEX_W = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_SEL        = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_READ_FMT          = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SUPPORTED_SAMPLES = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SUPPORTED_FORMATS = 4'd3;

   localparam logic [63:0] SUPPORTED_SAMPLES_RST = 64'h0000_0000_0001_00DF;
   localparam logic [63:0] SUPPORTED_FORMATS_RST = 64'h0000_0000_0000_000F;

   localparam logic [31:0] SAMPLE_RECORD_TYPE = 32'd9;

   localparam logic [3:0] KIND_HEADER     = 4'd0;
   localparam logic [3:0] KIND_IDENTIFIER = 4'd1;
   localparam logic [3:0] KIND_IP         = 4'd2;
   localparam logic [3:0] KIND_PID_TID    = 4'd3;
   localparam logic [3:0] KIND_TIME       = 4'd4;
   localparam logic [3:0] KIND_ADDR       = 4'd5;
   localparam logic [3:0] KIND_ID         = 4'd6;
   localparam logic [3:0] KIND_CPU        = 4'd7;
   localparam logic [3:0] KIND_COUNT      = 4'd8;
   localparam logic [3:0] KIND_ENABLED    = 4'd9;
   localparam logic [3:0] KIND_RUNNING    = 4'd10;
   localparam logic [3:0] KIND_VALUE      = 4'd11;
   localparam logic [3:0] KIND_VALUE_ID   = 4'd12;
   localparam logic [3:0] KIND_STATUS     = 4'd13;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_BAD_SAMPLE = 3'd1;
   localparam logic [2:0] ST_BAD_READ   = 3'd2;
   localparam logic [2:0] ST_NO_DATA    = 3'd3;
   localparam logic [2:0] ST_BAD_TYPE   = 3'd4;
   localparam logic [2:0] ST_TOO_MANY   = 3'd5;
   localparam logic [2:0] ST_SIZE       = 3'd6;

   localparam int SMP_IP = 0;
   localparam int SMP_TID = 1;
   localparam int SMP_TIME = 2;
   localparam int SMP_ADDR = 3;
   localparam int SMP_READ = 4;
   localparam int SMP_ID = 6;
   localparam int SMP_CPU = 7;
   localparam int SMP_IDENTIFIER = 16;

   localparam int FMT_ENABLED = 0;
   localparam int FMT_RUNNING = 1;
   localparam int FMT_ID = 2;
   localparam int FMT_GROUP = 3;

   typedef enum logic [16:0] {
      PH_IDLE  = 17'b0_0000_0000_0000_0001,
      PH_IDENT = 17'b0_0000_0000_0000_0010,
      PH_IP    = 17'b0_0000_0000_0000_0100,
      PH_TID   = 17'b0_0000_0000_0000_1000,
      PH_TIME  = 17'b0_0000_0000_0001_0000,
      PH_ADDR  = 17'b0_0000_0000_0010_0000,
      PH_ID    = 17'b0_0000_0000_0100_0000,
      PH_CPU   = 17'b0_0000_0000_1000_0000,
      PH_NR    = 17'b0_0000_0001_0000_0000,
      PH_GEN   = 17'b0_0000_0010_0000_0000,
      PH_GRUN  = 17'b0_0000_0100_0000_0000,
      PH_GVAL  = 17'b0_0000_1000_0000_0000,
      PH_GVID  = 17'b0_0001_0000_0000_0000,
      PH_SVAL  = 17'b0_0010_0000_0000_0000,
      PH_SEN   = 17'b0_0100_0000_0000_0000,
      PH_SRUN  = 17'b0_1000_0000_0000_0000,
      PH_SID   = 17'b1_0000_0000_0000_0000
   } phase_type;

   typedef struct packed {
      logic [3:0]  kind;
      logic [63:0] value;
      logic [5:0]  value_index;
      logic [2:0]  status;
      logic        last;
   } rsp_item_type;

   function automatic logic [3:0] phase_kind(input phase_type ph);
      logic [3:0] k;
      unique case (ph)
         PH_IDLE:  k = KIND_HEADER;
         PH_IDENT: k = KIND_IDENTIFIER;
         PH_IP:    k = KIND_IP;
         PH_TID:   k = KIND_PID_TID;
         PH_TIME:  k = KIND_TIME;
         PH_ADDR:  k = KIND_ADDR;
         PH_ID:    k = KIND_ID;
         PH_CPU:   k = KIND_CPU;
         PH_NR:    k = KIND_COUNT;
         PH_GEN:   k = KIND_ENABLED;
         PH_GRUN:  k = KIND_RUNNING;
         PH_GVAL:  k = KIND_VALUE;
         PH_GVID:  k = KIND_VALUE_ID;
         PH_SVAL:  k = KIND_VALUE;
         PH_SEN:   k = KIND_ENABLED;
         PH_SRUN:  k = KIND_RUNNING;
         PH_SID:   k = KIND_VALUE_ID;
         default:  k = KIND_HEADER;
      endcase
      return k;
   endfunction

endpackage

// ===== src/psr_if.sv =====
// Handshake channel interfaces of the perf sample record parser.
`timescale 1ns / 1ps
interface psr_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [63:0] word;

   modport source (output valid, output op, output word, input ready);
   modport sink (input valid, input op, input word, output ready);
endinterface

interface psr_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  kind;
   logic [63:0] value;
   logic [5:0]  value_index;
   logic [2:0]  status;
   logic        last;

   modport source (output valid, output kind, output value, output value_index,
                   output status, output last, input ready);
   modport sink (input valid, input kind, input value, input value_index,
                 input status, input last, output ready);
endinterface

interface psr_csr_if;
   logic        valid;
   logic        ready;
   logic [3:0]  index;
   logic [63:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/perf_sample_record_parser.sv =====
// Top level of the perf sample record parser: phase tracking and result queue.
//
// Usage: ring-buffer words enter on req_ch, one per transfer, with op low for a
// data word and op high to mark the end of the available data. Each transfer
// yields one or two transfers on rsp_ch: the decoded field tagged by kind and,
// when a record closes or fails, a status result with last set. The csr_ch
// port writes the sample selection, the read format and the two support masks
// by index; it is always ready and must only be used while no record result
// is pending.
// A req_ch transfer passes the input register and then the four-entry result
// queue before its first rsp_ch result. The block takes one word per cycle
// while at least two queue entries are free; a word that also closes a record
// needs two output transfers, so the result queue port sets the rate then. When
// rsp_ch stalls the queue fills and req_ch ready drops once fewer than two
// entries are free; no result is dropped. Reset returns to waiting for a
// header, empties the queue and loads the register reset values.
`timescale 1ns / 1ps
`include "perf_sample_record_parser_assert.svh"

module perf_sample_record_parser #(
   parameter int MAX_GROUP_VALUES = psr_pkg::MAX_GROUP_VALUES_DEF
) (
   input logic clock,
   input logic reset,
   psr_req_if.sink req_ch,
   psr_rsp_if.source rsp_ch,
   psr_csr_if.sink csr_ch
);
   import psr_pkg::*;

   localparam int CntW = $clog2(MAX_GROUP_VALUES + 1);
   localparam int WordsW = $clog2(2 * MAX_GROUP_VALUES + 13);

   logic [63:0] smp_sel_ff;
   logic [63:0] rd_fmt_ff;
   logic [63:0] supported_samples_ff;
   logic [63:0] supported_formats_ff;

   logic        in_valid_ff;
   logic        in_op_ff;
   logic [63:0] in_word_ff;

   phase_type         phase_ff, phase_in;
   logic [WordsW-1:0] words_ff, words_in;
   logic [15:0]       hdr_ff, hdr_in;
   logic [CntW-1:0]   gc_ff, gc_in;
   logic [CntW-1:0]   idx_ff, idx_in;

   rsp_item_type q_mem_ff [4];
   logic [1:0]   wr_ptr_ff;
   logic [1:0]   rd_ptr_ff;
   logic [2:0]   count_ff;

   logic         adv;
   logic         pop;
   logic         bad_sample;
   logic         bad_read;
   logic         fld_v;
   logic         fin_v;
   logic         go;
   logic [2:0]   fin_st;
   rsp_item_type fld;
   rsp_item_type fin;
   rsp_item_type slot0;
   rsp_item_type slot1;
   logic [1:0]   push_n;

   logic [CntW-1:0] gc_cur;
   logic [CntW-1:0] idx_cur;
   phase_type       np;
   logic            np_end;
   logic            rd_entry;
   logic [CntW-1:0] idx_nx;
   logic            grp_has;
   logic            grp_more;
   logic [7:0]      main_pres;

   always_ff @(posedge clock) begin
      if (reset) begin
         smp_sel_ff <= '0;
         rd_fmt_ff <= '0;
         supported_samples_ff <= SUPPORTED_SAMPLES_RST;
         supported_formats_ff <= SUPPORTED_FORMATS_RST;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_SAMPLE_SEL:        smp_sel_ff <= csr_ch.data;
            CSR_READ_FMT:          rd_fmt_ff <= csr_ch.data;
            CSR_SUPPORTED_SAMPLES: supported_samples_ff <= csr_ch.data;
            CSR_SUPPORTED_FORMATS: supported_formats_ff <= csr_ch.data;
            default: ;
         endcase
      end
   end

   assign csr_ch.ready = 1'b1;

   assign adv = in_valid_ff && (count_ff <= 3'd2);
   assign req_ch.ready = !in_valid_ff || adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_op_ff <= req_ch.op;
         in_word_ff <= req_ch.word;
      end
   end

   assign bad_sample = |(smp_sel_ff & ~supported_samples_ff);
   assign bad_read = |(rd_fmt_ff & ~supported_formats_ff);

   assign gc_cur = (phase_ff == PH_NR) ? CntW'(in_word_ff) : gc_ff;
   assign idx_cur = (phase_ff == PH_NR) ? '0 : idx_ff;
   assign grp_has = gc_cur != '0;
   assign grp_more = ({1'b0, idx_cur} + (CntW + 1)'(1)) < {1'b0, gc_cur};
   assign main_pres = {smp_sel_ff[SMP_CPU], smp_sel_ff[SMP_ID],
                       smp_sel_ff[SMP_ADDR], smp_sel_ff[SMP_TIME],
                       smp_sel_ff[SMP_TID], smp_sel_ff[SMP_IP],
                       smp_sel_ff[SMP_IDENTIFIER], 1'b0};

   // Successor phase, skipping fields that the registers leave out.
   always_comb begin
      logic       seen;
      logic       found;
      logic [2:0] pos;
      np = phase_ff;
      np_end = 1'b0;
      rd_entry = 1'b0;
      idx_nx = idx_cur;
      seen = 1'b0;
      found = 1'b0;
      pos = '0;
      for (int i = 0; i < 8; i++) begin
         if (seen && main_pres[i] && !found) begin
            found = 1'b1;
            pos = 3'(i);
         end
         seen = seen | phase_ff[i];
      end
      unique case (phase_ff)
         PH_IDLE, PH_IDENT, PH_IP, PH_TID, PH_TIME, PH_ADDR, PH_ID, PH_CPU: begin
            if (found) begin
               np = phase_type'(17'd1 << pos);
            end else if (!smp_sel_ff[SMP_READ]) begin
               np_end = 1'b1;
            end else begin
               rd_entry = 1'b1;
               np = rd_fmt_ff[FMT_GROUP] ? PH_NR : PH_SVAL;
            end
         end
         PH_NR, PH_GEN, PH_GRUN: begin
            if (phase_ff == PH_NR && rd_fmt_ff[FMT_ENABLED]) begin
               np = PH_GEN;
            end else if (phase_ff != PH_GRUN && rd_fmt_ff[FMT_RUNNING]) begin
               np = PH_GRUN;
            end else if (grp_has) begin
               np = PH_GVAL;
            end else begin
               np_end = 1'b1;
            end
         end
         PH_GVAL, PH_GVID: begin
            if (phase_ff == PH_GVAL && rd_fmt_ff[FMT_ID]) begin
               np = PH_GVID;
            end else if (grp_more) begin
               np = PH_GVAL;
               idx_nx = idx_cur + CntW'(1);
            end else begin
               np_end = 1'b1;
            end
         end
         PH_SVAL, PH_SEN, PH_SRUN, PH_SID: begin
            if (phase_ff == PH_SVAL && rd_fmt_ff[FMT_ENABLED]) begin
               np = PH_SEN;
            end else if ((phase_ff == PH_SVAL || phase_ff == PH_SEN) &&
                         rd_fmt_ff[FMT_RUNNING]) begin
               np = PH_SRUN;
            end else if (phase_ff != PH_SID && rd_fmt_ff[FMT_ID]) begin
               np = PH_SID;
            end else begin
               np_end = 1'b1;
            end
         end
         default: np_end = 1'b1;
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      words_in = words_ff;
      hdr_in = hdr_ff;
      gc_in = gc_ff;
      idx_in = idx_ff;
      fld_v = 1'b0;
      fin_v = 1'b0;
      fin_st = ST_OK;
      go = 1'b0;
      fld.kind = phase_kind(phase_ff);
      fld.value = (phase_ff == PH_CPU) ? {32'd0, in_word_ff[31:0]} : in_word_ff;
      fld.value_index = (phase_ff == PH_GVAL || phase_ff == PH_GVID) ? 6'(idx_ff) : '0;
      fld.status = ST_OK;
      fld.last = 1'b0;
      if (adv) begin
         if (phase_ff == PH_IDLE) begin
            if (bad_sample) begin
               fin_v = 1'b1;
               fin_st = ST_BAD_SAMPLE;
            end else if (in_op_ff) begin
               fin_v = 1'b1;
               fin_st = ST_NO_DATA;
            end else begin
               fld_v = 1'b1;
               if (in_word_ff[31:0] != SAMPLE_RECORD_TYPE) begin
                  fin_v = 1'b1;
                  fin_st = ST_BAD_TYPE;
               end else begin
                  words_in = WordsW'(1);
                  hdr_in = in_word_ff[63:48];
                  gc_in = '0;
                  idx_in = '0;
                  go = 1'b1;
               end
            end
         end else if (in_op_ff) begin
            fin_v = 1'b1;
            fin_st = ST_NO_DATA;
         end else begin
            fld_v = 1'b1;
            words_in = words_ff + WordsW'(1);
            if (phase_ff == PH_NR && in_word_ff > 64'(MAX_GROUP_VALUES)) begin
               fin_v = 1'b1;
               fin_st = ST_TOO_MANY;
            end else begin
               gc_in = gc_cur;
               go = 1'b1;
            end
         end
         if (go) begin
            idx_in = idx_nx;
            if (rd_entry && bad_read) begin
               fin_v = 1'b1;
               fin_st = ST_BAD_READ;
            end else if (np_end) begin
               fin_v = 1'b1;
               fin_st = ({64'(words_in), 3'b000} == 67'(hdr_in)) ? ST_OK : ST_SIZE;
            end else begin
               phase_in = np;
            end
         end
         if (fin_v) begin
            phase_in = PH_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         words_ff <= '0;
         hdr_ff <= '0;
         gc_ff <= '0;
         idx_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         words_ff <= words_in;
         hdr_ff <= hdr_in;
         gc_ff <= gc_in;
         idx_ff <= idx_in;
      end
   end

   assign fin.kind = KIND_STATUS;
   assign fin.value = '0;
   assign fin.value_index = '0;
   assign fin.status = fin_st;
   assign fin.last = 1'b1;

   assign slot0 = fld_v ? fld : fin;
   assign slot1 = fin;
   assign push_n = 2'(fld_v) + 2'(fin_v);

   assign pop = rsp_ch.valid && rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         q_mem_ff[wr_ptr_ff] <= slot0;
      end
      if (push_n == 2'd2) begin
         q_mem_ff[wr_ptr_ff + 2'd1] <= slot1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + push_n;
         rd_ptr_ff <= rd_ptr_ff + 2'(pop);
         count_ff <= count_ff + 3'(push_n) - 3'(pop);
      end
   end

   assign rsp_ch.valid = count_ff != 3'd0;
   assign rsp_ch.kind = q_mem_ff[rd_ptr_ff].kind;
   assign rsp_ch.value = q_mem_ff[rd_ptr_ff].value;
   assign rsp_ch.value_index = q_mem_ff[rd_ptr_ff].value_index;
   assign rsp_ch.status = q_mem_ff[rd_ptr_ff].status;
   assign rsp_ch.last = q_mem_ff[rd_ptr_ff].last;

   `PSR_ASSERT_IMPLY(a_queue_bound, clock, reset, 1'b1, count_ff <= 3'd4)
   `PSR_ASSERT_NEXT(a_end_goes_idle, clock, reset, adv && in_op_ff, phase_ff == PH_IDLE)
   `PSR_ASSERT_IMPLY(a_status_is_last, clock, reset,
                     rsp_ch.valid && rsp_ch.kind == KIND_STATUS, rsp_ch.last)
   `PSR_ASSERT_IMPLY(a_last_is_status, clock, reset,
                     rsp_ch.valid && rsp_ch.last, rsp_ch.kind == KIND_STATUS)
   `PSR_ASSERT_NEXT(a_take_holds_item, clock, reset, req_ch.valid && req_ch.ready,
                    in_valid_ff)

endmodule
